// File: hw/rtl/kbd_pkg.sv
// Shared types, constants and key maps for the scancode decoder.
// Depends on nothing; every other file in hw/rtl uses it.
package kbd_pkg;

  // Character ring geometry
  localparam int BufDepth = 256;
  localparam int PtrW     = (BufDepth > 1) ? $clog2(BufDepth) : 1;

  localparam int OpW   = 2;
  localparam int ByteW = 8;
  localparam int CodeW = 7;

  typedef enum logic [OpW-1:0] {
    OP_SCAN  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Set 1 make codes with special handling
  localparam logic [CodeW-1:0] ScanShiftL = 7'h2A;
  localparam logic [CodeW-1:0] ScanShiftR = 7'h36;
  localparam logic [CodeW-1:0] ScanCaps   = 7'h3A;
  localparam logic [CodeW-1:0] ScanUp     = 7'h48;
  localparam logic [CodeW-1:0] ScanDown   = 7'h50;
  localparam logic [CodeW-1:0] ScanLeft   = 7'h4B;
  localparam logic [CodeW-1:0] ScanRight  = 7'h4D;

  // Codes queued for arrow keys
  localparam logic [ByteW-1:0] KeyUp    = 8'h80;
  localparam logic [ByteW-1:0] KeyDown  = 8'h81;
  localparam logic [ByteW-1:0] KeyLeft  = 8'h82;
  localparam logic [ByteW-1:0] KeyRight = 8'h83;

  localparam logic [ByteW-1:0] LowerA    = 8'h61;
  localparam logic [ByteW-1:0] LowerZ    = 8'h7A;
  localparam logic [ByteW-1:0] CaseDelta = 8'h20;

  localparam int TableLen = 89;

  // US layout, unshifted
  localparam logic [ByteW-1:0] PlainMap [TableLen] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // US layout, shift held
  localparam logic [ByteW-1:0] ShiftMap [TableLen] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Decoder result for one scancode byte
  typedef struct packed {
    logic             shift_set;
    logic             shift_clr;
    logic             caps_tgl;
    logic             push;
    logic [ByteW-1:0] ch;
  } dec_t;

  // Ring request, already qualified by the stage advancing
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [ByteW-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic has_next;
  } ring_stat_t;

endpackage

// File: hw/rtl/kbd_if.sv
// Valid/ready channel interfaces for the decoder's input and result words.
// Depends on kbd_pkg for field widths.
interface kbd_in_if;
  logic                      valid;
  logic                      ready;
  logic [kbd_pkg::OpW-1:0]   op;
  logic [kbd_pkg::ByteW-1:0] scan_byte;

  modport source (output valid, output op, output scan_byte, input ready);
  modport sink   (input valid, input op, input scan_byte, output ready);
endinterface

interface kbd_out_if;
  logic                      valid;
  logic                      ready;
  logic [kbd_pkg::ByteW-1:0] char_out;
  logic                      char_valid;
  logic                      has_input;
  logic                      dropped;

  modport source (output valid, output char_out, output char_valid,
                  output has_input, output dropped, input ready);
  modport sink   (input valid, input char_out, input char_valid,
                  input has_input, input dropped, output ready);
endinterface

// File: hw/rtl/keyboard_scancode_decoder_fifo_unit.sv
// Scancode set 1 decoder with a character ring, one word in and one result word out.
// The input word is registered in the input register, then the result register
// (the ring read port is the char register).
// Throughput: one word per cycle while the result side is ready; a held result word stalls.
// Reset clears flags, pointers and valid bits at once; ring contents are not cleared.
module keyboard_scancode_decoder_fifo_unit (
  input  logic clk_i,
  input  logic rst_ni,
  kbd_in_if.sink    in_i,
  kbd_out_if.source out_o
);
  import kbd_pkg::*;

  // input register
  logic             s1_valid_q;
  logic [OpW-1:0]   s1_op_q;
  logic [ByteW-1:0] s1_byte_q;

  // result register (char data lives in the ring read register)
  logic out_valid_q;
  logic char_valid_q, char_valid_d;
  logic has_input_q, has_input_d;
  logic dropped_q, dropped_d;

  logic shift_q, shift_d;
  logic caps_q, caps_d;

  logic       s1_adv, is_scan, is_pop, is_clear;
  dec_t       dec;
  ring_req_t  req;
  ring_stat_t stat;
  logic [ByteW-1:0] rdata;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign is_scan  = (s1_op_q == OP_SCAN);
  assign is_pop   = (s1_op_q == OP_POP);
  assign is_clear = (s1_op_q == OP_CLEAR);

  kbd_decode u_decode (
    .scan_byte_i (s1_byte_q),
    .shift_i     (shift_q),
    .caps_i      (caps_q),
    .dec_o       (dec)
  );

  always_comb begin
    req.push  = s1_adv && is_scan && dec.push;
    req.pop   = s1_adv && is_pop;
    req.clear = s1_adv && is_clear;
    req.wdata = dec.ch;
  end

  kbd_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .stat_o  (stat),
    .rdata_o (rdata)
  );

  always_comb begin
    shift_d = shift_q;
    caps_d  = caps_q;
    if (s1_adv && is_scan) begin
      if (dec.shift_set) shift_d = 1'b1;
      if (dec.shift_clr) shift_d = 1'b0;
      if (dec.caps_tgl)  caps_d  = !caps_q;
    end
  end

  assign char_valid_d = is_pop && !stat.empty;
  assign dropped_d    = is_scan && dec.push && stat.full;
  assign has_input_d  = stat.has_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
    end else begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_op_q   <= in_i.op;
      s1_byte_q <= in_i.scan_byte;
    end
    if (s1_adv) begin
      char_valid_q <= char_valid_d;
      has_input_q  <= has_input_d;
      dropped_q    <= dropped_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.char_out   = char_valid_q ? rdata : '0;
  assign out_o.char_valid = char_valid_q;
  assign out_o.has_input  = has_input_q;
  assign out_o.dropped    = dropped_q;

endmodule

// File: hw/rtl/kbd_decode.sv
// Combinational set 1 scancode decoder: flag updates and the character to queue.
// Depends on kbd_pkg for key codes and the two layout maps.
module kbd_decode (
  input  logic [kbd_pkg::ByteW-1:0] scan_byte_i,
  input  logic                      shift_i,
  input  logic                      caps_i,
  output kbd_pkg::dec_t             dec_o
);
  import kbd_pkg::*;

  logic [CodeW-1:0] code;
  logic             release_key;
  logic             is_shift;
  logic [ByteW-1:0] map_ch;

  assign code        = scan_byte_i[CodeW-1:0];
  assign release_key = scan_byte_i[ByteW-1];
  assign is_shift    = (code == ScanShiftL) || (code == ScanShiftR);

  always_comb begin
    map_ch = '0;
    if (32'(code) < TableLen) begin
      if (shift_i) begin
        map_ch = ShiftMap[code];
      end else begin
        map_ch = PlainMap[code];
        if (caps_i && map_ch >= LowerA && map_ch <= LowerZ) begin
          map_ch = map_ch - CaseDelta;
        end
      end
    end
  end

  always_comb begin
    dec_o = '0;
    if (release_key) begin
      dec_o.shift_clr = is_shift;
    end else if (is_shift) begin
      dec_o.shift_set = 1'b1;
    end else if (code == ScanCaps) begin
      dec_o.caps_tgl = 1'b1;
    end else if (code == ScanUp) begin
      dec_o.push = 1'b1;
      dec_o.ch   = KeyUp;
    end else if (code == ScanDown) begin
      dec_o.push = 1'b1;
      dec_o.ch   = KeyDown;
    end else if (code == ScanLeft) begin
      dec_o.push = 1'b1;
      dec_o.ch   = KeyLeft;
    end else if (code == ScanRight) begin
      dec_o.push = 1'b1;
      dec_o.ch   = KeyRight;
    end else begin
      // zero map entries queue nothing
      dec_o.push = (map_ch != '0);
      dec_o.ch   = map_ch;
    end
  end

endmodule

// File: hw/rtl/kbd_ring.sv
// Character ring: one slot kept empty, one write and one registered read a cycle.
// Depends on kbd_pkg for depth, pointer width and the request/status structs.
module kbd_ring (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kbd_pkg::ring_req_t        req_i,
  output kbd_pkg::ring_stat_t       stat_o,
  output logic [kbd_pkg::ByteW-1:0] rdata_o
);
  import kbd_pkg::*;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(BufDepth - 1);

  logic [ByteW-1:0] mem [BufDepth];
  logic [ByteW-1:0] rdata_q;

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_inc, rd_inc;
  logic            full, empty, push_ok, pop_ok;

  assign wr_inc  = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
  assign rd_inc  = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
  assign full    = (wr_inc == rd_ptr_q);
  assign empty   = (wr_ptr_q == rd_ptr_q);
  assign push_ok = req_i.push && !full;
  assign pop_ok  = req_i.pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (req_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end else begin
      if (push_ok) wr_ptr_d = wr_inc;
      if (pop_ok)  rd_ptr_d = rd_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) mem[wr_ptr_q] <= req_i.wdata;
    if (pop_ok)  rdata_q <= mem[rd_ptr_q];
  end

  assign stat_o.full     = full;
  assign stat_o.empty    = empty;
  assign stat_o.has_next = (wr_ptr_d != rd_ptr_d);
  assign rdata_o         = rdata_q;

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q <= PtrLast)
    else $error("write pointer beyond ring depth");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= PtrLast)
    else $error("read pointer beyond ring depth");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clear |=> (wr_ptr_q == '0) && (rd_ptr_q == '0))
    else $error("clear did not reset pointers");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.push && full && !req_i.clear) |=> $stable(wr_ptr_q))
    else $error("push into full ring moved the write pointer");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.pop && empty && !req_i.clear) |=> $stable(rd_ptr_q))
    else $error("pop from empty ring moved the read pointer");

endmodule

// File: tb/sv/scancode_ring_checker.sv
// Checker for the scancode decoder: predicts each result word and compares it.
// Depends on kbd_pkg and the channel interfaces in kbd_if.sv.
// Watches both channels passively and reports a mismatch count and a pending count.
module scancode_ring_checker (
  input  logic clk_i,
  input  logic rst_ni,
  kbd_in_if    key_i,
  kbd_out_if   res_i,
  output int   mismatch_cnt_o,
  output int   pending_o
);
  import kbd_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             ch_vld;
    logic             has_chars;
    logic             lost;
  } key_result_t;

  // US layout, indexed by make code
  localparam logic [ByteW-1:0] UsPlain [TableLen] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [ByteW-1:0] UsShifted [TableLen] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [ByteW-1:0] char_mem [BufDepth];
  int unsigned      wr_ptr;
  int unsigned      rd_ptr;
  logic             shift_q;
  logic             caps_q;
  key_result_t      result_q [$];
  int               err_n;

  function automatic key_result_t decode_word(logic [OpW-1:0] op, logic [ByteW-1:0] b);
    key_result_t      r;
    logic [CodeW-1:0] code;
    logic [ByteW-1:0] c;
    r    = '0;
    code = b[CodeW-1:0];
    c    = '0;
    case (op)
      OP_SCAN: begin
        if (b[ByteW-1]) begin
          // only a shift release matters, everything else falls through
          if (code == ScanShiftL || code == ScanShiftR) shift_q = 1'b0;
        end else if (code == ScanShiftL || code == ScanShiftR) begin
          shift_q = 1'b1;
        end else if (code == ScanCaps) begin
          caps_q = !caps_q;
        end else if (code == ScanUp) begin
          c = KeyUp;
        end else if (code == ScanDown) begin
          c = KeyDown;
        end else if (code == ScanLeft) begin
          c = KeyLeft;
        end else if (code == ScanRight) begin
          c = KeyRight;
        end else if (code < TableLen) begin
          c = shift_q ? UsShifted[code] : UsPlain[code];
          if (!shift_q && caps_q && c >= LowerA && c <= LowerZ) c = c - CaseDelta;
        end
        // keep one slot free: drop the character when the ring would close
        if (c != '0) begin
          if ((wr_ptr + 1) % BufDepth == rd_ptr) begin
            r.lost = 1'b1;
          end else begin
            char_mem[wr_ptr] = c;
            wr_ptr = (wr_ptr + 1) % BufDepth;
          end
        end
      end
      OP_POP: begin
        if (wr_ptr != rd_ptr) begin
          r.ch     = char_mem[rd_ptr];
          r.ch_vld = 1'b1;
          rd_ptr   = (rd_ptr + 1) % BufDepth;
        end
      end
      OP_CLEAR: begin
        wr_ptr = 0;
        rd_ptr = 0;
      end
      default: ;
    endcase
    r.has_chars = (wr_ptr != rd_ptr);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t want;
    key_result_t got;
    if (!rst_ni) begin
      wr_ptr  = 0;
      rd_ptr  = 0;
      shift_q = 1'b0;
      caps_q  = 1'b0;
      err_n   = 0;
      result_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = {res_i.char_out, res_i.char_valid, res_i.has_input, res_i.dropped};
        if (result_q.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("%0t: result word with none outstanding: char_out %02h char_valid %b",
                     $time, got.ch, got.ch_vld, " has_input %b dropped %b",
                     got.has_chars, got.lost);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            err_n++;
            if (err_n <= 10)
              $display("%0t: result word mismatch: char_out exp %02h got %02h,", $time,
                       want.ch, got.ch, " char_valid exp %b got %b,", want.ch_vld, got.ch_vld,
                       " has_input exp %b got %b,", want.has_chars, got.has_chars,
                       " dropped exp %b got %b", want.lost, got.lost);
          end
        end
      end
      // the result of a word accepted now cannot come back in the same cycle
      if (key_i.valid && key_i.ready) result_q.push_back(decode_word(key_i.op, key_i.scan_byte));
      mismatch_cnt_o <= err_n;
      pending_o      <= result_q.size();
    end
  end

endmodule

// File: tb/sv/keyboard_scancode_decoder_fifo_unit_test.sv
// Top of the scancode decoder test: clock, reset, stimulus and the verdict.
// Depends on kbd_pkg, kbd_if.sv, the decoder RTL and scancode_ring_checker.
module keyboard_scancode_decoder_fifo_unit_test;
  import kbd_pkg::*;

  localparam logic [OpW-1:0] OpNone      = 2'd3;
  localparam int unsigned    RandomWords = 700;

  typedef enum int unsigned {RxAlways, RxCoin, RxSparse, RxBursty} rx_mode_e;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int          mismatch_cnt;
  int          pending_cnt;
  int unsigned burst_left = 0;
  int unsigned counted_n  = 0;
  int unsigned stall_left = 0;
  rx_mode_e    rx_mode    = RxAlways;

  kbd_in_if  key_ch ();
  kbd_out_if res_ch ();

  keyboard_scancode_decoder_fifo_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (key_ch),
    .out_o  (res_ch)
  );

  scancode_ring_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .key_i          (key_ch),
    .res_i          (res_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: switch at random between stall patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      rx_mode    <= rx_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (rx_mode)
      RxAlways: res_ch.ready <= 1'b1;
      RxCoin:   res_ch.ready <= 1'($urandom_range(0, 1));
      RxSparse: res_ch.ready <= (stall_left % 4 == 0);
      default:  res_ch.ready <= (stall_left % 9 < 3);
    endcase
  end

  // Present one word in a burst and hold it until the decoder takes it
  task automatic send_word(input logic [OpW-1:0] op, input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        key_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    key_ch.valid     <= 1'b1;
    key_ch.op        <= op;
    key_ch.scan_byte <= b;
    do @(posedge clk); while (!key_ch.ready);
    counted_n++;
  endtask

  initial begin
    int unsigned      kind;
    int unsigned      n;
    logic [CodeW-1:0] key;
    key_ch.valid     = 1'b0;
    key_ch.op        = OP_SCAN;
    key_ch.scan_byte = '0;
    res_ch.ready     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop and clear on an empty ring, unused op
    send_word(OP_POP, 8'h00);
    send_word(OpNone, 8'hFF);
    send_word(OP_CLEAR, 8'h00);
    // plain letter, caps lock, shift over caps, both shift keys
    send_word(OP_SCAN, 8'h1E);
    send_word(OP_SCAN, {1'b0, ScanCaps});
    send_word(OP_SCAN, 8'h2C);
    send_word(OP_SCAN, {1'b0, ScanShiftL});
    send_word(OP_SCAN, 8'h02);
    send_word(OP_SCAN, 8'h10);
    send_word(OP_SCAN, {1'b1, ScanShiftL});
    send_word(OP_SCAN, {1'b0, ScanCaps});
    send_word(OP_SCAN, {1'b0, ScanShiftR});
    send_word(OP_SCAN, 8'h35);
    send_word(OP_SCAN, {1'b1, ScanShiftR});
    // arrows, empty table entry, keypad minus, out of table, prefix, other release
    send_word(OP_SCAN, {1'b0, ScanUp});
    send_word(OP_SCAN, {1'b0, ScanDown});
    send_word(OP_SCAN, {1'b0, ScanLeft});
    send_word(OP_SCAN, {1'b0, ScanRight});
    send_word(OP_SCAN, 8'h00);
    send_word(OP_SCAN, 8'h4A);
    send_word(OP_SCAN, 8'h59);
    send_word(OP_SCAN, 8'hE0);
    send_word(OP_SCAN, 8'h9E);
    send_word(OP_POP, 8'h5A);
    send_word(OP_POP, 8'hA5);
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_POP, 8'h00);

    counted_n = 0;
    // overrun the ring with letter and bracket key presses, then drain part of it
    repeat (260) send_word(OP_SCAN, 8'($urandom_range(8'h10, 8'h1B)));
    repeat (60) send_word(OP_POP, 8'($urandom));

    while (counted_n < RandomWords) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          key = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, TableLen - 1));
          send_word(OP_SCAN, {1'b0, key});
          if ($urandom_range(0, 1)) send_word(OP_SCAN, {1'b1, key});
        end
      end else if (kind < 55) begin
        send_word(OP_SCAN, {1'b0, $urandom_range(0, 1) ? ScanShiftL : ScanShiftR});
        n = $urandom_range(1, 6);
        repeat (n) send_word(OP_SCAN, 8'($urandom_range(0, TableLen - 1)));
        send_word(OP_SCAN, {1'b1, $urandom_range(0, 1) ? ScanShiftL : ScanShiftR});
      end else if (kind < 60) begin
        send_word(OP_SCAN, {1'b0, ScanCaps});
      end else if (kind < 65) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       send_word(OP_SCAN, {1'b0, ScanUp});
            1:       send_word(OP_SCAN, {1'b0, ScanDown});
            2:       send_word(OP_SCAN, {1'b0, ScanLeft});
            default: send_word(OP_SCAN, {1'b0, ScanRight});
          endcase
        end
      end else if (kind < 90) begin
        n = $urandom_range(1, 16);
        repeat (n) send_word(OP_POP, 8'($urandom));
      end else if (kind < 92) begin
        send_word(OP_CLEAR, 8'($urandom));
      end else begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
